/* sv/assert_macros.svh */
// assertion macros shared by the csv parser rtl
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CSVP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, disabled during reset
`define CSVP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* sv/csvp_pkg.sv */
// types and constants for the strict csv byte parser
// no dependencies; imported by every module of the block
package csvp_pkg;

  // character codes
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // config register reset values
  localparam logic [15:0] FIELD_LIMIT_RST  = 16'd256;
  localparam logic [7:0]  COLUMN_LIMIT_RST = 8'd64;
  localparam logic [15:0] RECORD_LIMIT_RST = 16'd65535;

  // parse modes
  typedef enum logic [1:0] {
    MODE_PLAIN   = 2'd0,
    MODE_QUOTED  = 2'd1,
    MODE_PENDING = 2'd2,
    MODE_AFTER   = 2'd3
  } mode_t;

  // sticky error codes
  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_FIELD_BIG = 4'd1,
    ERR_COLUMNS   = 4'd2,
    ERR_RECORDS   = 4'd3,
    ERR_SPACE_AFT = 4'd4,
    ERR_CHAR_AFT  = 4'd5,
    ERR_MISPLACED = 4'd6,
    ERR_UNCLOSED  = 4'd7,
    ERR_NO_HEADER = 4'd8
  } err_t;

  // config register indexes
  typedef enum logic [1:0] {
    CFG_FIELD_LIMIT  = 2'd0,
    CFG_COLUMN_LIMIT = 2'd1,
    CFG_RECORD_LIMIT = 2'd2
  } cfg_idx_t;

  // config register values
  typedef struct packed {
    logic [15:0] field_limit;
    logic [7:0]  column_limit;
    logic [15:0] record_limit;
  } cfg_t;

  // parser state
  typedef struct packed {
    mode_t       mode;
    logic [15:0] field_len;
    logic [7:0]  col_cnt;
    logic [16:0] row_cnt;
    logic        saw_content;
    logic        swallow_lf;
    err_t        err;
  } pstate_t;

  // one result beat
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] content_byte;
    logic       field_done;
    logic       row_done;
    logic [3:0] err_code;
    logic       finished;
  } res_t;

  localparam pstate_t PSTATE_RST = '{
    mode:        MODE_PLAIN,
    field_len:   16'd0,
    col_cnt:     8'd0,
    row_cnt:     17'd0,
    saw_content: 1'b0,
    swallow_lf:  1'b0,
    err:         ERR_NONE
  };

endpackage

/* sv/csvp_cfg.sv */
// configuration registers of the csv parser
// depends on csvp_pkg for the register indexes and reset values
module csvp_cfg
  import csvp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [1:0]  index,
  input  logic [15:0] wdata,
  output cfg_t        cfg
);

  logic [15:0] field_limit_r;
  logic [7:0]  column_limit_r;
  logic [15:0] record_limit_r;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_limit_r  <= FIELD_LIMIT_RST;
      column_limit_r <= COLUMN_LIMIT_RST;
      record_limit_r <= RECORD_LIMIT_RST;
    end else if (wr_en) begin
      unique case (index)
        CFG_FIELD_LIMIT:  field_limit_r  <= wdata;
        CFG_COLUMN_LIMIT: column_limit_r <= wdata[7:0];
        CFG_RECORD_LIMIT: record_limit_r <= wdata;
        default: ;
      endcase
    end
  end

  assign cfg.field_limit  = field_limit_r;
  assign cfg.column_limit = column_limit_r;
  assign cfg.record_limit = record_limit_r;

endmodule

/* sv/csvp_step.sv */
// single-byte parse step: current state and one beat in, next state and result out
// depends on csvp_pkg for state, result and character constants
module csvp_step
  import csvp_pkg::*;
(
  input  cfg_t       cfg,
  input  pstate_t    cur,
  input  logic       end_of_text,
  input  logic [7:0] text_byte,
  output pstate_t    nxt,
  output res_t       res
);

  always_comb begin
    pstate_t    n;
    logic       take;
    logic       do_push;
    logic       do_comma;
    logic       do_row;
    logic       do_cr;
    logic       do_after;
    logic       do_plain;
    logic       is_eol;
    err_t       raise;
    logic       r_valid;
    logic       r_field;
    logic       r_row;
    logic [16:0] row_inc;

    n        = cur;
    take     = 1'b1;
    do_push  = 1'b0;
    do_comma = 1'b0;
    do_row   = 1'b0;
    do_cr    = 1'b0;
    do_after = 1'b0;
    do_plain = 1'b0;
    raise    = ERR_NONE;
    r_valid  = 1'b0;
    r_field  = 1'b0;
    r_row    = 1'b0;
    is_eol   = (text_byte == CH_CR) || (text_byte == CH_LF);
    row_inc  = cur.row_cnt + 17'd1;

    // classify the beat
    if (end_of_text) begin
      if (cur.err == ERR_NONE) begin
        if (cur.mode == MODE_QUOTED) begin
          raise = ERR_UNCLOSED;
        end else if (cur.mode == MODE_PENDING || cur.mode == MODE_AFTER ||
                     cur.field_len != 16'd0 || cur.col_cnt != 8'd0) begin
          do_row = 1'b1;
        end
      end
    end else if (cur.err == ERR_NONE) begin
      if (cur.swallow_lf) begin
        n.swallow_lf = 1'b0;
        if (text_byte == CH_LF) take = 1'b0;
      end
      if (take) begin
        unique case (cur.mode)
          MODE_QUOTED: begin
            if (text_byte == CH_QUOTE) begin
              n.mode = MODE_PENDING;
            end else begin
              n.saw_content = 1'b1;
              do_push       = 1'b1;
            end
          end
          MODE_PENDING: begin
            if (text_byte == CH_QUOTE) begin
              n.mode  = MODE_QUOTED;
              do_push = 1'b1;
            end else begin
              n.mode   = MODE_AFTER;
              do_after = 1'b1;
            end
          end
          MODE_AFTER: do_after = 1'b1;
          MODE_PLAIN: do_plain = 1'b1;
        endcase
      end
      // after a closing quote only a separator may follow
      if (do_after) begin
        priority if (text_byte == CH_COMMA) begin
          do_comma = 1'b1;
        end else if (is_eol) begin
          do_row = 1'b1;
          do_cr  = (text_byte == CH_CR);
        end else if (text_byte == CH_SPACE || text_byte == CH_TAB) begin
          raise = ERR_SPACE_AFT;
        end else begin
          raise = ERR_CHAR_AFT;
        end
      end
      // unquoted field bytes
      if (do_plain) begin
        priority if (text_byte == CH_QUOTE) begin
          if (cur.field_len != 16'd0) begin
            raise = ERR_MISPLACED;
          end else begin
            n.mode        = MODE_QUOTED;
            n.saw_content = 1'b1;
          end
        end else if (text_byte == CH_COMMA) begin
          do_comma = 1'b1;
        end else if (is_eol) begin
          do_row = 1'b1;
          do_cr  = (text_byte == CH_CR);
        end else begin
          n.saw_content = 1'b1;
          do_push       = 1'b1;
        end
      end
    end

    // classification errors
    if (raise != ERR_NONE) n.err = raise;

    // content byte, length check covers escaped quotes
    if (do_push) begin
      if ({1'b0, cur.field_len} + 17'd1 > {1'b0, cfg.field_limit}) begin
        n.err = ERR_FIELD_BIG;
      end else begin
        n.field_len = cur.field_len + 16'd1;
        r_valid     = 1'b1;
      end
    end

    // comma closes a field
    if (do_comma) begin
      priority if (cur.field_len > cfg.field_limit) begin
        n.err = ERR_FIELD_BIG;
      end else if ({1'b0, cur.col_cnt} + 9'd1 >= {1'b0, cfg.column_limit}) begin
        n.err = ERR_COLUMNS;
      end else begin
        n.col_cnt   = cur.col_cnt + 8'd1;
        n.field_len = 16'd0;
        n.mode      = MODE_PLAIN;
        r_field     = 1'b1;
      end
    end

    // row end, an empty single-field row is skipped
    if (do_row) begin
      priority if (cur.field_len > cfg.field_limit) begin
        n.err = ERR_FIELD_BIG;
      end else if ({1'b0, cur.col_cnt} + 9'd1 > {1'b0, cfg.column_limit}) begin
        n.err = ERR_COLUMNS;
      end else begin
        n.mode = MODE_PLAIN;
        if (!(cur.col_cnt == 8'd0 && cur.field_len == 16'd0 && !n.saw_content)) begin
          n.row_cnt = row_inc;
          if (row_inc > {1'b0, cfg.record_limit} + 17'd1) begin
            n.err = ERR_RECORDS;
          end else begin
            n.col_cnt     = 8'd0;
            n.field_len   = 16'd0;
            n.saw_content = 1'b0;
            r_field       = 1'b1;
            r_row         = 1'b1;
          end
        end
      end
    end

    // swallow the lf of a crlf pair
    if (do_cr && n.err == ERR_NONE) n.swallow_lf = 1'b1;

    // text with no kept row
    if (end_of_text && cur.err == ERR_NONE && n.err == ERR_NONE && n.row_cnt == 17'd0) begin
      n.err = ERR_NO_HEADER;
    end

    // result beat, flags masked once an error is set
    res.byte_valid   = r_valid && (n.err == ERR_NONE);
    res.content_byte = res.byte_valid ? text_byte : 8'd0;
    res.field_done   = r_field && (n.err == ERR_NONE);
    res.row_done     = r_row && (n.err == ERR_NONE);
    res.err_code     = n.err;
    res.finished     = end_of_text;

    // end beat starts a fresh text
    nxt = end_of_text ? PSTATE_RST : n;
  end

endmodule

/* sv/strict_csv_byte_parser_core.sv */
// strict csv byte parser: each input beat passes the input register, then the result register
// throughput one byte per cycle while out_stall is low, set by the combinational parse step between
// the input register and the result register
// synchronous active-low reset clears parse state, the valid bits of both beat registers and
// restores config limits to 256 / 64 / 65535; an end beat clears parse state
module strict_csv_byte_parser_core
  import csvp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_end_of_text,
  input  logic [7:0]  in_text_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_byte_valid,
  output logic [7:0]  out_content_byte,
  output logic        out_field_done,
  output logic        out_row_done,
  output logic [3:0]  out_error_code,
  output logic        out_finished,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

`include "assert_macros.svh"

  cfg_t       cfg;
  pstate_t    st_r;
  pstate_t    st_nxt;
  res_t       res_nxt;
  res_t       res_r;
  logic       in_vld_r;
  logic       in_end_r;
  logic [7:0] in_byte_r;
  logic       out_vld_r;
  logic       advance;
  logic       step_go;

  // config registers
  csvp_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  // handshake control
  assign advance  = !out_vld_r || !out_stall;
  assign step_go  = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;

  // input beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_end_r  <= in_end_of_text;
      in_byte_r <= in_text_byte;
    end
  end

  // parse step
  csvp_step u_step (
    .cfg         (cfg),
    .cur         (st_r),
    .end_of_text (in_end_r),
    .text_byte   (in_byte_r),
    .nxt         (st_nxt),
    .res         (res_nxt)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= PSTATE_RST;
    end else if (step_go) begin
      st_r <= st_nxt;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_byte_valid   = res_r.byte_valid;
  assign out_content_byte = res_r.content_byte;
  assign out_field_done   = res_r.field_done;
  assign out_row_done     = res_r.row_done;
  assign out_error_code   = res_r.err_code;
  assign out_finished     = res_r.finished;

  // an error beat carries no content or markers
  `CSVP_ASSERT_NOW(a_err_masks_flags, out_vld_r && res_r.err_code != ERR_NONE,
    !res_r.byte_valid && !res_r.field_done && !res_r.row_done)
  // a row end also closes its field, and never with a content byte
  `CSVP_ASSERT_NOW(a_row_has_field, out_vld_r && res_r.row_done,
    res_r.field_done && !res_r.byte_valid)
  // an error holds until the end beat
  `CSVP_ASSERT_NEXT(a_err_sticky, step_go && !in_end_r && st_r.err != ERR_NONE,
    st_r.err == $past(st_r.err))
  // the end beat returns the parser to its start state
  `CSVP_ASSERT_NEXT(a_end_clears, step_go && in_end_r,
    st_r.err == ERR_NONE && st_r.mode == MODE_PLAIN && st_r.row_cnt == 17'd0)

endmodule
